// ----- src/pps_pkg.sv -----
// shared types, constants and helpers of the priority scheduler
package pps_pkg;

    localparam int NUM_PROCS_DEF = 8;
    localparam int ID_W          = 8;
    localparam int TIME_W        = 16;
    localparam int SLOT_W        = 3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [TIME_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] priority_level;
    } t_entry;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] r;
        r = (v == TICK_MAX) ? TICK_MAX : v + TIME_W'(1);
        return r;
    endfunction

endpackage

// ----- src/pps_mem.sv -----
// process table memory with per-slot valid bits and a registered read port
module pps_mem #(
    parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF,
    parameter int AW        = $clog2(NUM_PROCS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  pps_pkg::t_entry  i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output pps_pkg::t_entry  o_rd_data
);

    pps_pkg::t_entry        r_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0]   r_valid;
    pps_pkg::t_entry        r_rd_data;
    logic                   r_rd_live;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_live <= r_valid[i_rd_addr];
            end
        end
    end

    // a slot never written reads as empty
    assign o_rd_data = r_rd_live ? r_rd_data : '0;

endmodule

// ----- src/pps_pick.sv -----
// running selection of the best ready slot during a table scan
module pps_pick #(
    parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF,
    parameter int AW        = $clog2(NUM_PROCS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_cmp_en,
    input  logic [AW-1:0]                 i_cmp_slot,
    input  pps_pkg::t_entry               i_entry,
    input  logic [pps_pkg::TIME_W-1:0]    i_tick,
    output logic                          o_found,
    output logic [AW-1:0]                 o_slot,
    output pps_pkg::t_entry               o_entry
);

    logic            r_found;
    logic [AW-1:0]   r_slot;
    pps_pkg::t_entry r_entry;
    logic            w_ready;
    logic            w_take;

    assign w_ready = (i_entry.burst != '0) && (i_tick >= i_entry.arrival);
    // later slots win ties, hence <=
    assign w_take  = i_cmp_en && w_ready &&
                     (!r_found || (i_entry.priority_level <= r_entry.priority_level));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_slot  <= i_cmp_slot;
            r_entry <= i_entry;
        end
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;
    assign o_entry = r_entry;

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// preemptive priority scheduler top level: command sequencer, tick counter, results
//
// One command channel: a request is taken at a rising edge with start high and
// busy low. command = load writes the given slot (slot_index beyond the table
// is ignored); command = tick runs one time step over the table.
// Every request yields exactly one result, shown for one cycle with o_done high.
// A load's result carries all fields zero and appears the cycle after the
// request; busy stays low, so loads can be issued every cycle.
// A tick reads the table memory one slot per cycle (a single read port with a
// registered read), keeps the best ready slot, then writes the decremented burst
// back in a write-back state. busy stays high through the scan and the write-back,
// and the result shows in the first cycle with busy low, so a new tick is taken
// only once the last one is through. The scan over the memory port takes longest.
// An idle tick (no ready slot) still advances the tick counter, which saturates
// at 65535, and reports o_selected_valid low with all fields zero.
// Reset (synchronous, active low) empties every slot through the valid bits
// at once and clears the tick counter; no clearing pass is needed.
// Results cannot be held off: the receiver must take o_done when it shows.
module preemptive_priority_scheduler #(
    parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic [pps_pkg::SLOT_W-1:0]    i_slot_index,
    input  logic [pps_pkg::ID_W-1:0]      i_process_id,
    input  logic [pps_pkg::TIME_W-1:0]    i_burst_length,
    input  logic [pps_pkg::TIME_W-1:0]    i_arrival_time,
    input  logic [pps_pkg::TIME_W-1:0]    i_priority_level,
    output logic                          o_done,
    output logic                          o_selected_valid,
    output logic [pps_pkg::ID_W-1:0]      o_selected_id,
    output logic [pps_pkg::SLOT_W-1:0]    o_selected_slot,
    output logic                          o_finished,
    output logic [pps_pkg::TIME_W-1:0]    o_finish_time
);

    localparam int AW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam int WW = (AW > pps_pkg::SLOT_W) ? AW : pps_pkg::SLOT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [CW-1:0]               r_idx, n_idx;
    logic                        r_cmp, n_cmp;
    logic [AW-1:0]               r_cmp_slot, n_cmp_slot;
    logic [pps_pkg::TIME_W-1:0]  r_tick, n_tick;

    logic                        r_done;
    logic                        r_sel_valid;
    logic [pps_pkg::ID_W-1:0]    r_sel_id;
    logic [pps_pkg::SLOT_W-1:0]  r_sel_slot;
    logic                        r_finished;
    logic [pps_pkg::TIME_W-1:0]  r_finish_time;

    logic                        w_accept;
    logic [WW-1:0]               w_slot_ext;
    logic                        w_slot_ok;
    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    pps_pkg::t_entry             w_wr_data;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    pps_pkg::t_entry             w_rd_data;
    logic                        w_clear;
    logic                        w_found;
    logic [AW-1:0]               w_best_slot;
    pps_pkg::t_entry             w_best;
    logic [WW-1:0]               w_best_ext;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_slot_ext = WW'(i_slot_index);
    assign w_slot_ok  = ({{(32 - WW){1'b0}}, w_slot_ext} < 32'(NUM_PROCS));
    assign w_best_ext = WW'(w_best_slot);

    pps_mem #(
        .NUM_PROCS (NUM_PROCS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pps_pick #(
        .NUM_PROCS (NUM_PROCS),
        .AW        (AW)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_clear),
        .i_cmp_en   (r_cmp),
        .i_cmp_slot (r_cmp_slot),
        .i_entry    (w_rd_data),
        .i_tick     (r_tick),
        .o_found    (w_found),
        .o_slot     (w_best_slot),
        .o_entry    (w_best)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cmp      = 1'b0;
        n_cmp_slot = r_cmp_slot;
        n_tick     = r_tick;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_slot_ext[AW-1:0];
        w_wr_data.id             = i_process_id;
        w_wr_data.burst          = i_burst_length;
        w_wr_data.arrival        = i_arrival_time;
        w_wr_data.priority_level = i_priority_level;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx[AW-1:0];
        w_clear    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == pps_pkg::CMD_LOAD)) begin
                    w_wr_en = w_slot_ok;
                end else if (w_accept) begin
                    // first read goes out with the request
                    w_clear    = 1'b1;
                    w_rd_en    = 1'b1;
                    w_rd_addr  = '0;
                    n_idx      = CW'(1);
                    n_cmp      = 1'b1;
                    n_cmp_slot = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == CW'(NUM_PROCS)) begin
                    n_state = S_WB;
                end else begin
                    w_rd_en    = 1'b1;
                    n_idx      = r_idx + CW'(1);
                    n_cmp      = 1'b1;
                    n_cmp_slot = r_idx[AW-1:0];
                end
            end
            S_WB: begin
                w_wr_en         = w_found;
                w_wr_addr       = w_best_slot;
                w_wr_data       = w_best;
                w_wr_data.burst = w_best.burst - pps_pkg::TIME_W'(1);
                n_tick          = pps_pkg::sat_inc(r_tick);
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cmp   <= 1'b0;
            r_tick  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cmp   <= n_cmp;
            r_tick  <= n_tick;
            r_done  <= (w_accept && (i_command == pps_pkg::CMD_LOAD)) ||
                       (r_state == S_WB);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_slot <= n_cmp_slot;
        if (r_state == S_WB && w_found) begin
            r_sel_valid   <= 1'b1;
            r_sel_id      <= w_best.id;
            r_sel_slot    <= w_best_ext[pps_pkg::SLOT_W-1:0];
            r_finished    <= (w_best.burst == pps_pkg::TIME_W'(1));
            r_finish_time <= (w_best.burst == pps_pkg::TIME_W'(1)) ?
                             pps_pkg::sat_inc(r_tick) : '0;
        end else begin
            r_sel_valid   <= 1'b0;
            r_sel_id      <= '0;
            r_sel_slot    <= '0;
            r_finished    <= 1'b0;
            r_finish_time <= '0;
        end
    end

    assign o_done           = r_done;
    assign o_selected_valid = r_sel_valid;
    assign o_selected_id    = r_sel_id;
    assign o_selected_slot  = r_sel_slot;
    assign o_finished       = r_finished;
    assign o_finish_time    = r_finish_time;

endmodule

// ----- src/pps_checker.sv -----
// port-level checks of the priority scheduler, bound to the top level
module pps_props (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_command,
    input logic                          o_done,
    input logic                          o_selected_valid,
    input logic [pps_pkg::ID_W-1:0]      o_selected_id,
    input logic [pps_pkg::SLOT_W-1:0]    o_selected_slot,
    input logic                          o_finished,
    input logic [pps_pkg::TIME_W-1:0]    o_finish_time
);

    a_load_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == pps_pkg::CMD_LOAD)) |=>
            (o_done && !o_selected_valid && !busy))
        else $error("load request not answered next cycle");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == pps_pkg::CMD_TICK)) |=> (busy && !o_done))
        else $error("tick request did not start a scan");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_selected_valid) |->
            ((o_selected_id == '0) && (o_selected_slot == '0) &&
             !o_finished && (o_finish_time == '0)))
        else $error("empty result carries data");

    a_sel_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_selected_valid || o_finished) |-> (o_done && o_selected_valid))
        else $error("selection shown outside a result");

    a_finish_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_finished) |-> (o_finish_time == '0))
        else $error("finish time without completion");

endmodule

bind preemptive_priority_scheduler pps_props u_pps_props (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_command        (i_command),
    .o_done           (o_done),
    .o_selected_valid (o_selected_valid),
    .o_selected_id    (o_selected_id),
    .o_selected_slot  (o_selected_slot),
    .o_finished       (o_finished),
    .o_finish_time    (o_finish_time)
);

// ----- bench/pps_checker.sv -----
// request/result monitor of the priority scheduler: table prediction and result compare
module pps_checker #(
    parameter int NUM_PROCS = pps_pkg::NUM_PROCS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_command,
    input  logic [pps_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [pps_pkg::ID_W-1:0]   i_process_id,
    input  logic [pps_pkg::TIME_W-1:0] i_burst_length,
    input  logic [pps_pkg::TIME_W-1:0] i_arrival_time,
    input  logic [pps_pkg::TIME_W-1:0] i_priority_level,
    input  logic                       i_done,
    input  logic                       i_selected_valid,
    input  logic [pps_pkg::ID_W-1:0]   i_selected_id,
    input  logic [pps_pkg::SLOT_W-1:0] i_selected_slot,
    input  logic                       i_finished,
    input  logic [pps_pkg::TIME_W-1:0] i_finish_time,
    output int                         o_fail_count,
    output int                         o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pps_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] slot;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
    } t_pick;

    logic [TIME_W-1:0] burst_left   [NUM_PROCS];
    logic [TIME_W-1:0] arrives_at   [NUM_PROCS];
    logic [TIME_W-1:0] prio_of      [NUM_PROCS];
    logic [ID_W-1:0]   id_of        [NUM_PROCS];
    logic [TIME_W-1:0] tick_now;

    t_pick expected_picks[$];
    int    fail_count = 0;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    function automatic logic [TIME_W-1:0] tick_after(input logic [TIME_W-1:0] t);
        logic [TIME_W:0] wide;
        wide = {1'b0, t} + (TIME_W + 1)'(1);
        return wide[TIME_W] ? t : wide[TIME_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // one request through the scheduler table, queues the result it must give
    task automatic run_scheduler_step();
        t_pick pick;
        int    best;
        pick = '0;
        best = -1;
        if (i_command == CMD_LOAD) begin
            if (i_slot_index < NUM_PROCS) begin
                id_of[i_slot_index]      = i_process_id;
                burst_left[i_slot_index] = i_burst_length;
                arrives_at[i_slot_index] = i_arrival_time;
                prio_of[i_slot_index]    = i_priority_level;
            end
        end else begin
            // later slots win ties, hence <=
            for (int i = 0; i < NUM_PROCS; i++) begin
                if (burst_left[i] != 0 && tick_now >= arrives_at[i] &&
                    (best < 0 || prio_of[i] <= prio_of[best])) begin
                    best = i;
                end
            end
            if (best >= 0) begin
                burst_left[best] = burst_left[best] - 1'b1;
                pick.valid = 1'b1;
                pick.id    = id_of[best];
                pick.slot  = SLOT_W'(best);
                if (burst_left[best] == 0) begin
                    pick.finished    = 1'b1;
                    pick.finish_time = tick_after(tick_now);
                end
            end
            tick_now = tick_after(tick_now);
        end
        expected_picks.push_back(pick);
    endtask

    always @(posedge i_clk) begin
        t_pick want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PROCS; i++) begin
                burst_left[i] = '0;
                arrives_at[i] = '0;
                prio_of[i]    = '0;
                id_of[i]      = '0;
            end
            tick_now = '0;
            expected_picks.delete();
        end else begin
            if (start && !busy) run_scheduler_step();
            if (i_done) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("o_done with no request outstanding", 1, 0);
                end else begin
                    want = expected_picks.pop_front();
                    if (i_selected_valid !== want.valid)
                        report_mismatch("o_selected_valid", i_selected_valid, want.valid);
                    if (i_selected_id !== want.id)
                        report_mismatch("o_selected_id", i_selected_id, want.id);
                    if (i_selected_slot !== want.slot)
                        report_mismatch("o_selected_slot", i_selected_slot, want.slot);
                    if (i_finished !== want.finished)
                        report_mismatch("o_finished", i_finished, want.finished);
                    if (i_finish_time !== want.finish_time)
                        report_mismatch("o_finish_time", i_finish_time, want.finish_time);
                end
            end
        end
        o_fail_count    = fail_count;
        o_pending_count = expected_picks.size();
    end

endmodule

// ----- bench/testbench.sv -----
// top of the priority scheduler bench: clock, reset, request stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pps_pkg::*;

    localparam int NUM_PROCS      = NUM_PROCS_DEF;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 400;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              start            = 1'b0;
    logic              busy;
    logic              i_command        = CMD_LOAD;
    logic [SLOT_W-1:0] i_slot_index     = '0;
    logic [ID_W-1:0]   i_process_id     = '0;
    logic [TIME_W-1:0] i_burst_length   = '0;
    logic [TIME_W-1:0] i_arrival_time   = '0;
    logic [TIME_W-1:0] i_priority_level = '0;
    logic              o_done;
    logic              o_selected_valid;
    logic [ID_W-1:0]   o_selected_id;
    logic [SLOT_W-1:0] o_selected_slot;
    logic              o_finished;
    logic [TIME_W-1:0] o_finish_time;

    int fail_count;
    int pending_count;
    int ticks_sent    = 0;
    int requests_sent = 0;
    int idle_cycles   = 0;
    bit gaps_on       = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    preemptive_priority_scheduler #(.NUM_PROCS(NUM_PROCS)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_slot_index     (i_slot_index),
        .i_process_id     (i_process_id),
        .i_burst_length   (i_burst_length),
        .i_arrival_time   (i_arrival_time),
        .i_priority_level (i_priority_level),
        .o_done           (o_done),
        .o_selected_valid (o_selected_valid),
        .o_selected_id    (o_selected_id),
        .o_selected_slot  (o_selected_slot),
        .o_finished       (o_finished),
        .o_finish_time    (o_finish_time)
    );

    pps_checker #(.NUM_PROCS(NUM_PROCS)) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_slot_index     (i_slot_index),
        .i_process_id     (i_process_id),
        .i_burst_length   (i_burst_length),
        .i_arrival_time   (i_arrival_time),
        .i_priority_level (i_priority_level),
        .i_done           (o_done),
        .i_selected_valid (o_selected_valid),
        .i_selected_id    (o_selected_id),
        .i_selected_slot  (o_selected_slot),
        .i_finished       (o_finished),
        .i_finish_time    (o_finish_time),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    // nothing accepted on either side for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // arrival a few ticks ahead of the block's own counter, clipped at the top
    function automatic logic [TIME_W-1:0] arrival_soon(input int ahead);
        int t;
        t = ticks_sent + ahead;
        return (t > 65535) ? '1 : TIME_W'(t);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic issue_request(input logic cmd, input int slot, input int id,
                                 input int burst, input int arrival, input int prio);
        start            <= 1'b1;
        i_command        <= cmd;
        i_slot_index     <= SLOT_W'(slot);
        i_process_id     <= ID_W'(id);
        i_burst_length   <= TIME_W'(burst);
        i_arrival_time   <= TIME_W'(arrival);
        i_priority_level <= TIME_W'(prio);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cmd == CMD_TICK) ticks_sent++;
        requests_sent++;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    task automatic load_slot(input int slot, input int id, input int burst,
                             input int arrival, input int prio);
        issue_request(CMD_LOAD, slot, id, burst, arrival, prio);
    endtask

    // the unused fields of a tick carry junk
    task automatic run_tick();
        issue_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic empty_table();
        for (int s = 0; s < NUM_PROCS; s++)
            load_slot(s, $urandom, 0, $urandom, $urandom);
    endtask

    initial begin
        int kind;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle tick, tie on priority, late arrival, preemption
        run_tick();
        load_slot(0, 8'hFF, 16'd1, 16'd0, 16'hFFFF);
        load_slot(7, 8'h00, 16'd2, 16'd0, 16'hFFFF);
        load_slot(3, 8'hA5, 16'd1, arrival_soon(4), 16'd0);
        repeat (5) run_tick();
        load_slot(2, 8'h5A, 16'd3, 16'd0, 16'd10);
        run_tick();
        load_slot(4, 8'h3C, 16'd1, 16'd0, 16'd5);
        repeat (2) run_tick();
        // emptying a slot part-way through its burst
        load_slot(2, 8'h5A, 16'd0, 16'd0, 16'd10);
        run_tick();
        load_slot(1, 8'h81, 16'hFFFF, 16'hFFFF, 16'h0000);
        load_slot(6, 8'h7E, 16'd2, 16'h0000, 16'h8000);
        repeat (3) run_tick();

        while (requests_sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                // a batch of short processes, then ticks with the odd late load
                if ($urandom_range(0, 1) == 0) empty_table();
                repeat ($urandom_range(1, NUM_PROCS)) begin
                    load_slot($urandom, $urandom, $urandom_range(1, 6),
                              arrival_soon($urandom_range(0, 8)),
                              ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3));
                end
                repeat ($urandom_range(1, 20)) begin
                    if ($urandom_range(0, 5) == 0)
                        load_slot($urandom, $urandom, $urandom_range(1, 4),
                                  arrival_soon($urandom_range(0, 2)), $urandom_range(0, 2));
                    run_tick();
                end
            end else if (kind == 7) begin
                load_slot($urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 3))
                    load_slot($urandom, $urandom, 0, $urandom, $urandom);
            end else begin
                repeat ($urandom_range(1, 6)) run_tick();
            end
        end

        // last part: no gaps, back-to-back requests
        gaps_on = 1'b0;
        empty_table();
        load_slot(2, $urandom, 16'hFFFF, 16'd0, 16'hFFFF);
        load_slot(1, $urandom, 16'd3, arrival_soon(2), 16'd0);
        load_slot(4, $urandom, 16'd1, arrival_soon(5), 16'd0);
        load_slot(6, $urandom, 16'd2, 16'hFFFF, 16'hFFFF);
        repeat (12) run_tick();
        start <= 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (NUM_PROCS + 4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
